@@ sv/wmul_pkg.sv @@
// Shared types and constants for the wide multiplier.
package wmul_pkg;

    localparam int unsigned DATA_W   = 64;
    localparam int unsigned OPCODE_W = 2;

    typedef enum logic [OPCODE_W-1:0] {
        OP_UU     = 2'd0,
        OP_SS     = 2'd1,
        OP_SU     = 2'd2,
        OP_UU_ALT = 2'd3
    } opcode_t;

endpackage

@@ sv/wide_multiplier_64x64_signed_modes.sv @@
// Each stage from input request to result is a register.
// Throughput: one request per cycle while m_tready is high; stage depth is set by the
// half-width partial-product multipliers and the full-width product add.
// Each stage holds under backpressure and fills its own bubble.
// Reset (rst_n low, asynchronous) clears only the stage valid bits.
module wide_multiplier_64x64_signed_modes #(
    parameter int unsigned OPERAND_WIDTH = 64
) (
    input  logic                            clk,
    input  logic                            rst_n,
    input  logic                            s_tvalid,
    output logic                            s_tready,
    input  logic [2*wmul_pkg::DATA_W-1:0]   s_tdata,   // operand_a, operand_b
    input  logic [wmul_pkg::OPCODE_W-1:0]   s_tuser,   // opcode
    output logic                            m_tvalid,
    input  logic                            m_tready,
    output logic [2*wmul_pkg::DATA_W-1:0]   m_tdata    // product_low, product_high
);

    localparam int unsigned HALF_W = (OPERAND_WIDTH + 1) / 2;
    localparam int unsigned PP_W   = 2 * HALF_W;

    logic                     p_valid;
    logic                     p_ready;
    logic [OPERAND_WIDTH-1:0] p_a;
    logic [OPERAND_WIDTH-1:0] p_b;
    logic [OPERAND_WIDTH-1:0] p_corr;
    logic                     q_valid;
    logic                     q_ready;
    logic [PP_W-1:0]          q_ll;
    logic [PP_W-1:0]          q_hh;
    logic [PP_W:0]            q_mid;
    logic [OPERAND_WIDTH-1:0] q_corr;
    logic [OPERAND_WIDTH-1:0] r_low;
    logic [OPERAND_WIDTH-1:0] r_high;
    logic [wmul_pkg::DATA_W-1:0] low_ext;
    logic [wmul_pkg::DATA_W-1:0] high_ext;

    wmul_prep #(
        .OPERAND_WIDTH (OPERAND_WIDTH)
    ) u_prep (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (s_tvalid),
        .in_ready  (s_tready),
        .opcode    (s_tuser),
        .operand_a (s_tdata[wmul_pkg::DATA_W-1:0]),
        .operand_b (s_tdata[2*wmul_pkg::DATA_W-1:wmul_pkg::DATA_W]),
        .out_valid (p_valid),
        .out_ready (p_ready),
        .a_out     (p_a),
        .b_out     (p_b),
        .corr_out  (p_corr)
    );

    wmul_partial #(
        .OPERAND_WIDTH (OPERAND_WIDTH)
    ) u_partial (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (p_valid),
        .in_ready  (p_ready),
        .a_in      (p_a),
        .b_in      (p_b),
        .corr_in   (p_corr),
        .out_valid (q_valid),
        .out_ready (q_ready),
        .ll_out    (q_ll),
        .hh_out    (q_hh),
        .mid_out   (q_mid),
        .corr_out  (q_corr)
    );

    wmul_combine #(
        .OPERAND_WIDTH (OPERAND_WIDTH)
    ) u_combine (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (q_valid),
        .in_ready  (q_ready),
        .ll_in     (q_ll),
        .hh_in     (q_hh),
        .mid_in    (q_mid),
        .corr_in   (q_corr),
        .out_valid (m_tvalid),
        .out_ready (m_tready),
        .low_out   (r_low),
        .high_out  (r_high)
    );

    // Bits above the operand width read as zero.
    always_comb
    begin
        low_ext  = '0;
        high_ext = '0;
        low_ext[OPERAND_WIDTH-1:0]  = r_low;
        high_ext[OPERAND_WIDTH-1:0] = r_high;
    end

    assign m_tdata = {high_ext, low_ext};

endmodule

@@ sv/wmul_prep.sv @@
// Operand masking and high-half sign correction term, first pipeline stage.
module wmul_prep #(
    parameter int unsigned OPERAND_WIDTH = 64
) (
    input  logic                              clk,
    input  logic                              rst_n,
    input  logic                              in_valid,
    output logic                              in_ready,
    input  logic [wmul_pkg::OPCODE_W-1:0]     opcode,
    input  logic [wmul_pkg::DATA_W-1:0]       operand_a,
    input  logic [wmul_pkg::DATA_W-1:0]       operand_b,
    output logic                              out_valid,
    input  logic                              out_ready,
    output logic [OPERAND_WIDTH-1:0]          a_out,
    output logic [OPERAND_WIDTH-1:0]          b_out,
    output logic [OPERAND_WIDTH-1:0]          corr_out
);

    logic [OPERAND_WIDTH-1:0] a_m;
    logic [OPERAND_WIDTH-1:0] b_m;
    logic [OPERAND_WIDTH-1:0] corr_next;
    logic [OPERAND_WIDTH-1:0] a_reg;
    logic [OPERAND_WIDTH-1:0] b_reg;
    logic [OPERAND_WIDTH-1:0] corr_reg;
    logic                     valid_reg;
    logic                     en;
    wmul_pkg::opcode_t        op;

    assign a_m = operand_a[OPERAND_WIDTH-1:0];
    assign b_m = operand_b[OPERAND_WIDTH-1:0];
    assign op  = wmul_pkg::opcode_t'(opcode);

    // Subtract the other operand from the high half for each negative signed operand.
    always_comb
    begin
        unique case (op)
            wmul_pkg::OP_SS:
            begin
                corr_next = (a_m[OPERAND_WIDTH-1] ? b_m : '0)
                          + (b_m[OPERAND_WIDTH-1] ? a_m : '0);
            end
            wmul_pkg::OP_SU:
            begin
                corr_next = a_m[OPERAND_WIDTH-1] ? b_m : '0;
            end
            default:
            begin
                corr_next = '0;
            end
        endcase
    end

    assign en       = !valid_reg || out_ready;
    assign in_ready = en;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else if (en)
        begin
            valid_reg <= in_valid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (en && in_valid)
        begin
            a_reg    <= a_m;
            b_reg    <= b_m;
            corr_reg <= corr_next;
        end
    end

    assign out_valid = valid_reg;
    assign a_out     = a_reg;
    assign b_out     = b_reg;
    assign corr_out  = corr_reg;

endmodule

@@ sv/wmul_partial.sv @@
// Half-width partial products and middle-term sum, two pipeline stages.
module wmul_partial #(
    parameter int unsigned OPERAND_WIDTH = 64
) (
    input  logic                                   clk,
    input  logic                                   rst_n,
    input  logic                                   in_valid,
    output logic                                   in_ready,
    input  logic [OPERAND_WIDTH-1:0]               a_in,
    input  logic [OPERAND_WIDTH-1:0]               b_in,
    input  logic [OPERAND_WIDTH-1:0]               corr_in,
    output logic                                   out_valid,
    input  logic                                   out_ready,
    output logic [2*((OPERAND_WIDTH+1)/2)-1:0]     ll_out,
    output logic [2*((OPERAND_WIDTH+1)/2)-1:0]     hh_out,
    output logic [2*((OPERAND_WIDTH+1)/2):0]       mid_out,
    output logic [OPERAND_WIDTH-1:0]               corr_out
);

    localparam int unsigned HALF_W = (OPERAND_WIDTH + 1) / 2;
    localparam int unsigned PP_W   = 2 * HALF_W;

    logic [PP_W-1:0]          ax;
    logic [PP_W-1:0]          bx;
    logic [PP_W-1:0]          ll_reg;
    logic [PP_W-1:0]          lh_reg;
    logic [PP_W-1:0]          hl_reg;
    logic [PP_W-1:0]          hh_reg;
    logic [OPERAND_WIDTH-1:0] corr1_reg;
    logic                     v1_reg;
    logic                     en1;
    logic [PP_W-1:0]          ll2_reg;
    logic [PP_W-1:0]          hh2_reg;
    logic [PP_W:0]            mid_reg;
    logic [OPERAND_WIDTH-1:0] corr2_reg;
    logic                     v2_reg;
    logic                     en2;

    always_comb
    begin
        ax = '0;
        bx = '0;
        ax[OPERAND_WIDTH-1:0] = a_in;
        bx[OPERAND_WIDTH-1:0] = b_in;
    end

    assign en2      = !v2_reg || out_ready;
    assign en1      = !v1_reg || en2;
    assign in_ready = en1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            v1_reg <= 1'b0;
            v2_reg <= 1'b0;
        end
        else
        begin
            if (en1)
            begin
                v1_reg <= in_valid;
            end
            if (en2)
            begin
                v2_reg <= v1_reg;
            end
        end
    end

    // Four half-width multiplies, each registered.
    always_ff @(posedge clk)
    begin
        if (en1 && in_valid)
        begin
            ll_reg    <= PP_W'(ax[HALF_W-1:0])    * PP_W'(bx[HALF_W-1:0]);
            lh_reg    <= PP_W'(ax[HALF_W-1:0])    * PP_W'(bx[PP_W-1:HALF_W]);
            hl_reg    <= PP_W'(ax[PP_W-1:HALF_W]) * PP_W'(bx[HALF_W-1:0]);
            hh_reg    <= PP_W'(ax[PP_W-1:HALF_W]) * PP_W'(bx[PP_W-1:HALF_W]);
            corr1_reg <= corr_in;
        end
    end

    always_ff @(posedge clk)
    begin
        if (en2 && v1_reg)
        begin
            ll2_reg   <= ll_reg;
            hh2_reg   <= hh_reg;
            mid_reg   <= {1'b0, lh_reg} + {1'b0, hl_reg};
            corr2_reg <= corr1_reg;
        end
    end

    assign out_valid = v2_reg;
    assign ll_out    = ll2_reg;
    assign hh_out    = hh2_reg;
    assign mid_out   = mid_reg;
    assign corr_out  = corr2_reg;

endmodule

@@ sv/wmul_combine.sv @@
// Final product assembly and high-half signed correction, two pipeline stages.
module wmul_combine #(
    parameter int unsigned OPERAND_WIDTH = 64
) (
    input  logic                                   clk,
    input  logic                                   rst_n,
    input  logic                                   in_valid,
    output logic                                   in_ready,
    input  logic [2*((OPERAND_WIDTH+1)/2)-1:0]     ll_in,
    input  logic [2*((OPERAND_WIDTH+1)/2)-1:0]     hh_in,
    input  logic [2*((OPERAND_WIDTH+1)/2):0]       mid_in,
    input  logic [OPERAND_WIDTH-1:0]               corr_in,
    output logic                                   out_valid,
    input  logic                                   out_ready,
    output logic [OPERAND_WIDTH-1:0]               low_out,
    output logic [OPERAND_WIDTH-1:0]               high_out
);

    localparam int unsigned HALF_W = (OPERAND_WIDTH + 1) / 2;
    localparam int unsigned PP_W   = 2 * HALF_W;
    localparam int unsigned FULL_W = 2 * PP_W;

    logic [FULL_W-1:0]        mid_ext;
    logic [FULL_W-1:0]        full_next;
    logic [FULL_W-1:0]        full_reg;
    logic [OPERAND_WIDTH-1:0] corr_reg;
    logic                     v1_reg;
    logic                     en1;
    logic [OPERAND_WIDTH-1:0] low_reg;
    logic [OPERAND_WIDTH-1:0] high_reg;
    logic                     v2_reg;
    logic                     en2;

    always_comb
    begin
        mid_ext = '0;
        mid_ext[PP_W:0] = mid_in;
        full_next = {hh_in, ll_in} + (mid_ext << HALF_W);
    end

    assign en2      = !v2_reg || out_ready;
    assign en1      = !v1_reg || en2;
    assign in_ready = en1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            v1_reg <= 1'b0;
            v2_reg <= 1'b0;
        end
        else
        begin
            if (en1)
            begin
                v1_reg <= in_valid;
            end
            if (en2)
            begin
                v2_reg <= v1_reg;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (en1 && in_valid)
        begin
            full_reg <= full_next;
            corr_reg <= corr_in;
        end
    end

    // High half wraps modulo 2^OPERAND_WIDTH.
    always_ff @(posedge clk)
    begin
        if (en2 && v1_reg)
        begin
            low_reg  <= full_reg[OPERAND_WIDTH-1:0];
            high_reg <= full_reg[2*OPERAND_WIDTH-1:OPERAND_WIDTH] - corr_reg;
        end
    end

    assign out_valid = v2_reg;
    assign low_out   = low_reg;
    assign high_out  = high_reg;

endmodule

@@ test/tb_wide_multiplier_64x64_signed_modes.sv @@
// Testbench for the 64x64 multiplier with unsigned, signed and mixed-sign modes.
`timescale 1ns / 1ps

module tb_wide_multiplier_64x64_signed_modes;

    localparam int unsigned W          = wmul_pkg::DATA_W;
    localparam int          IDLE_LIMIT = 5000;
    localparam int          DRAIN_WAIT = 20;

    typedef struct packed {
        wmul_pkg::opcode_t op;
        logic [W-1:0]      a;
        logic [W-1:0]      b;
        logic              no_gap;
    } mul_req_t;

    typedef struct packed {
        logic [W-1:0]   low;
        logic [W-1:0]   high;
    } mul_res_t;

    logic                             clk = 1'b0;
    logic                             rst_n = 1'b0;
    logic                             s_tvalid = 1'b0;
    logic                             s_tready;
    logic [2*W-1:0]                   s_tdata = '0;                // operand_a, operand_b
    logic [wmul_pkg::OPCODE_W-1:0]    s_tuser = wmul_pkg::OP_UU;   // opcode
    logic                             m_tvalid;
    logic                             m_tready = 1'b0;
    logic [2*W-1:0]                   m_tdata;                     // product_low, product_high

    mul_req_t   operand_q[$];
    mul_res_t   product_fifo[$];
    int         fail_count = 0;
    int         send_gap = 0;
    int         recv_gap = 0;
    int         hold_left = 0;
    int         calm_left = 0;
    int         results_seen = 0;
    bit         long_hold_done = 1'b0;
    int         idle_cycles = 0;

    wide_multiplier_64x64_signed_modes dut (
        .clk      (clk),
        .rst_n    (rst_n),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .s_tuser  (s_tuser),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata)
    );

    always
    begin
        #2 clk = 1'b1;
        #2 clk = 1'b0;
    end

    // Full 128-bit product; high half corrected for each negative signed operand.
    function automatic mul_res_t mul_product(wmul_pkg::opcode_t op, logic [W-1:0] a,
                                             logic [W-1:0] b);
        logic [2*W-1:0] full;
        mul_res_t       r;
        full   = {{W{1'b0}}, a} * {{W{1'b0}}, b};
        r.low  = full[W-1:0];
        r.high = full[2*W-1:W];
        if (op == wmul_pkg::OP_SS)
        begin
            if (a[W-1])
                r.high = r.high - b;
            if (b[W-1])
                r.high = r.high - a;
        end
        else if (op == wmul_pkg::OP_SU)
        begin
            if (a[W-1])
                r.high = r.high - b;
        end
        return r;
    endfunction

    // Mostly short gaps, now and then a long one.
    function automatic int pick_gap();
        int r;
        r = $urandom_range(0, 99);
        if (r < 45)
            return 0;
        else if (r < 85)
            return $urandom_range(1, 3);
        else if (r < 97)
            return $urandom_range(4, 12);
        return $urandom_range(20, 45);
    endfunction

    function automatic logic [W-1:0] pick_operand();
        case ($urandom_range(0, 9))
            0: return '0;
            1: return '1;
            2: return {1'b1, {(W-1){1'b0}}};
            3: return {1'b0, {(W-1){1'b1}}};
            4: return W'($urandom_range(0, 255));
            5: return {1'b1, 31'($urandom), 32'($urandom)};
            6: return -W'($urandom_range(1, 255));
            default: return {32'($urandom), 32'($urandom)};
        endcase
    endfunction

    // Driver: a request stays on the bus until accepted.
    always @(posedge clk or negedge rst_n)
    begin
        mul_req_t req;
        if (!rst_n)
        begin
            s_tvalid <= 1'b0;
            s_tdata  <= '0;
            s_tuser  <= wmul_pkg::OP_UU;
        end
        else
        begin
            if (s_tvalid && s_tready)
                product_fifo.push_back(mul_product(wmul_pkg::opcode_t'(s_tuser),
                                                   s_tdata[W-1:0], s_tdata[2*W-1:W]));
            if (!s_tvalid || s_tready)
            begin
                if (send_gap != 0)
                begin
                    send_gap = send_gap - 1;
                    s_tvalid <= 1'b0;
                end
                else if (operand_q.size() != 0)
                begin
                    req = operand_q.pop_front();
                    s_tvalid <= 1'b1;
                    s_tdata  <= {req.b, req.a};
                    s_tuser  <= req.op;
                    send_gap = req.no_gap ? 0 : pick_gap();
                end
                else
                    s_tvalid <= 1'b0;
            end
        end
    end

    // Monitor and receiver backpressure.
    always @(posedge clk or negedge rst_n)
    begin
        mul_res_t exp_res;
        if (!rst_n)
            m_tready <= 1'b0;
        else
        begin
            if (m_tvalid && m_tready)
            begin
                results_seen = results_seen + 1;
                if (product_fifo.size() == 0)
                begin
                    $error("unexpected result low=%h high=%h",
                           m_tdata[W-1:0], m_tdata[2*W-1:W]);
                    fail_count = fail_count + 1;
                end
                else
                begin
                    exp_res = product_fifo.pop_front();
                    if (m_tdata[W-1:0] !== exp_res.low)
                    begin
                        $error("product_low expected %h got %h", exp_res.low, m_tdata[W-1:0]);
                        fail_count = fail_count + 1;
                    end
                    if (m_tdata[2*W-1:W] !== exp_res.high)
                    begin
                        $error("product_high expected %h got %h",
                               exp_res.high, m_tdata[2*W-1:W]);
                        fail_count = fail_count + 1;
                    end
                end
            end

            // one long hold-off mid-run so the pipeline fills and stalls the input
            if (!long_hold_done && results_seen >= 300)
            begin
                long_hold_done = 1'b1;
                hold_left = 200;
            end
            if (calm_left == 0 && hold_left == 0 && $urandom_range(0, 299) == 0)
                calm_left = 100;

            if (hold_left != 0)
            begin
                hold_left = hold_left - 1;
                m_tready <= 1'b0;
            end
            else if (calm_left != 0)
            begin
                calm_left = calm_left - 1;
                m_tready <= 1'b1;
            end
            else if (recv_gap != 0)
            begin
                recv_gap = recv_gap - 1;
                m_tready <= 1'b0;
            end
            else
            begin
                m_tready <= 1'b1;
                if ($urandom_range(0, 2) == 0)
                    recv_gap = pick_gap();
            end
        end
    end

    // Watchdog on cycles with no transfer on either side.
    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if ((s_tvalid && s_tready) || (m_tvalid && m_tready))
                idle_cycles = 0;
            else
                idle_cycles = idle_cycles + 1;
            if (idle_cycles >= IDLE_LIMIT)
            begin
                $display("Verification failed");
                $finish;
            end
        end
    end

    initial
    begin
        logic [W-1:0] edge_a[6];
        logic [W-1:0] edge_b[6];
        mul_req_t     req;

        edge_a = '{'1, {1'b1, {(W-1){1'b0}}}, {1'b1, {(W-1){1'b0}}},
                   {1'b0, {(W-1){1'b1}}}, '0, W'(1)};
        edge_b = '{'1, {1'b1, {(W-1){1'b0}}}, '1,
                   {1'b1, {(W-1){1'b0}}}, '1, {1'b1, {(W-1){1'b0}}}};

        repeat (10) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // directed: edge operands under every opcode, including the alias of unsigned
        for (int op = 0; op < 4; op++)
            for (int k = 0; k < 6; k++)
            begin
                req.op     = wmul_pkg::opcode_t'(op);
                req.a      = edge_a[k];
                req.b      = edge_b[k];
                req.no_gap = 1'b0;
                operand_q.push_back(req);
            end

        // sender waits for the directed batch to drain completely
        while (operand_q.size() != 0 || s_tvalid || product_fifo.size() != 0)
            @(posedge clk);

        for (int i = 0; i < 1026; i++)
        begin
            req.op     = wmul_pkg::opcode_t'($urandom_range(0, 3));
            req.a      = pick_operand();
            req.b      = pick_operand();
            req.no_gap = ((i / 128) % 4) == 1;
            operand_q.push_back(req);
        end

        while (operand_q.size() != 0 || s_tvalid || product_fifo.size() != 0)
            @(posedge clk);
        repeat (DRAIN_WAIT) @(posedge clk);

        if (fail_count == 0)
            $display("Verification passed");
        else
            $display("Verification failed");
        $finish;
    end

endmodule

@@ wide_multiplier_64x64_signed_modes.f @@
sv/wmul_pkg.sv
sv/wmul_prep.sv
sv/wmul_partial.sv
sv/wmul_combine.sv
sv/wide_multiplier_64x64_signed_modes.sv
test/tb_wide_multiplier_64x64_signed_modes.sv
